/* rtl/core/rvdec_pkg.sv */
// ----------------------------------------------------------------------------
// rvdec_pkg
// Shared types, opcodes and operation codes for the RV32IM decoder.
// ----------------------------------------------------------------------------
package rvdec_pkg;

  localparam int unsigned INSTR_W = 32;

  // major opcodes
  localparam logic [6:0] OPC_LOAD     = 7'h03;
  localparam logic [6:0] OPC_MISC_MEM = 7'h0F;
  localparam logic [6:0] OPC_OP_IMM   = 7'h13;
  localparam logic [6:0] OPC_AUIPC    = 7'h17;
  localparam logic [6:0] OPC_STORE    = 7'h23;
  localparam logic [6:0] OPC_OP       = 7'h33;
  localparam logic [6:0] OPC_LUI      = 7'h37;
  localparam logic [6:0] OPC_BRANCH   = 7'h63;
  localparam logic [6:0] OPC_JALR     = 7'h67;
  localparam logic [6:0] OPC_JAL      = 7'h6F;
  localparam logic [6:0] OPC_SYSTEM   = 7'h73;

  // funct7 codes
  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_MULDIV = 7'h01;
  localparam logic [6:0] F7_ALT = 7'h20;

  // funct3 codes that the decoder tests by name
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SW   = 3'd2;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_PRIV = 3'd0;
  localparam logic [2:0] F3_RSVD = 3'd4;

  // exact system words
  localparam logic [31:0] WORD_ECALL  = 32'h0000_0073;
  localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;
  localparam logic [31:0] WORD_MRET   = 32'h3020_0073;
  localparam logic [31:0] WORD_SRET   = 32'h1020_0073;
  localparam logic [31:0] WORD_WFI    = 32'h1050_0073;

  typedef enum logic [3:0] {
    UNIT_ALU     = 4'd0,
    UNIT_LOAD    = 4'd1,
    UNIT_STORE   = 4'd2,
    UNIT_BRANCH  = 4'd3,
    UNIT_CSR     = 4'd4,
    UNIT_ECALL   = 4'd5,
    UNIT_EBREAK  = 4'd6,
    UNIT_MRET    = 4'd7,
    UNIT_NOP     = 4'd8,
    UNIT_ILLEGAL = 4'd9
  } unit_e_t;

  // alu operations; other units carry funct3 zero-extended
  localparam logic [4:0] ALU_ADD   = 5'd0;
  localparam logic [4:0] ALU_SUB   = 5'd1;
  localparam logic [4:0] ALU_SLL   = 5'd2;
  localparam logic [4:0] ALU_SLT   = 5'd3;
  localparam logic [4:0] ALU_SLTU  = 5'd4;
  localparam logic [4:0] ALU_XOR   = 5'd5;
  localparam logic [4:0] ALU_SRL   = 5'd6;
  localparam logic [4:0] ALU_SRA   = 5'd7;
  localparam logic [4:0] ALU_OR    = 5'd8;
  localparam logic [4:0] ALU_AND   = 5'd9;
  localparam logic [4:0] ALU_MUL   = 5'd10;
  localparam logic [4:0] ALU_AUIPC = 5'd18;
  localparam logic [4:0] ALU_JAL   = 5'd19;
  localparam logic [4:0] ALU_JALR  = 5'd20;

  // declared high field first so the packed bits put unit at bit 0
  typedef struct packed {
    logic               uses_pc;
    logic               uses_immediate;
    logic [4:0]         src2_reg;
    logic [4:0]         src1_reg;
    logic [4:0]         dest_reg;
    logic signed [31:0] immediate;
    logic [4:0]         operation;
    unit_e_t            unit;
  } uop_t;

  localparam int unsigned UOP_W = $bits(uop_t);
  localparam int unsigned UOP_BYTES_W = ((UOP_W + 7) / 8) * 8;

  // funct3 -> base alu op for funct7 zero
  function automatic logic [4:0] base_op(input logic [2:0] f3);
    logic [4:0] op;
    unique case (f3)
      3'd0:    op = ALU_ADD;
      3'd1:    op = ALU_SLL;
      3'd2:    op = ALU_SLT;
      3'd3:    op = ALU_SLTU;
      3'd4:    op = ALU_XOR;
      3'd5:    op = ALU_SRL;
      3'd6:    op = ALU_OR;
      default: op = ALU_AND;
    endcase
    return op;
  endfunction

endpackage

/* rtl/core/rv32im_instruction_decoder_top.sv */
// ----------------------------------------------------------------------------
// rv32im_instruction_decoder_top
// RV32IM decoder: input register, decode logic, micro-op output register.
// ----------------------------------------------------------------------------
// Path: each input beat is held in the input register, decoded, then held in the micro-op output register.
// Throughput: one instruction per cycle; both registers pass a beat while
// taking the next one, so only the output ready can slow the stream.
// Reset (rst, synchronous): clears both valid flags; the data registers are not reset.
module rv32im_instruction_decoder_top import rvdec_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [INSTR_W-1:0]     s_axis_tdata,  // [31:0] instr_word
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [3:0] unit, [8:4] operation, [40:9] immediate, [45:41] dest_reg,
  // [50:46] src1_reg, [55:51] src2_reg, [56] uses_immediate, [57] uses_pc
  output logic [UOP_BYTES_W-1:0] m_axis_tdata
);

  logic               mid_valid;
  logic               mid_ready;
  logic [INSTR_W-1:0] mid_word;
  uop_t               dec_uop;
  logic [UOP_W-1:0]   out_bits;
  uop_t               out_uop;

  rvdec_slice #(
    .WIDTH (INSTR_W)
  ) u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (s_axis_tdata),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_data  (mid_word)
  );

  rvdec_logic u_logic (
    .instr_word (mid_word),
    .uop        (dec_uop)
  );

  rvdec_slice #(
    .WIDTH (UOP_W)
  ) u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mid_valid),
    .in_ready  (mid_ready),
    .in_data   (dec_uop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_bits)
  );

  assign out_uop      = uop_t'(out_bits);
  assign m_axis_tdata = {{(UOP_BYTES_W - UOP_W){1'b0}}, out_bits};

  // trap, nop and illegal ops carry nothing else
  a_special_clean: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (out_uop.unit == UNIT_ECALL || out_uop.unit == UNIT_EBREAK ||
                      out_uop.unit == UNIT_MRET || out_uop.unit == UNIT_NOP ||
                      out_uop.unit == UNIT_ILLEGAL)
    |-> out_bits[UOP_W-1:4] == '0)
    else $error("special unit with nonzero payload");

  a_no_dest: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (out_uop.unit == UNIT_STORE || out_uop.unit == UNIT_BRANCH)
    |-> out_uop.dest_reg == 5'd0)
    else $error("store/branch with destination register");

  a_pc_ops: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && out_uop.uses_pc
    |-> out_uop.unit == UNIT_ALU &&
        (out_uop.operation == ALU_AUIPC || out_uop.operation == ALU_JAL))
    else $error("pc operand on wrong op");

  a_pass: assert property (@(posedge clk) disable iff (rst)
    mid_valid && mid_ready |=> m_axis_tvalid)
    else $error("decoded beat lost");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && !mid_valid)
    else $error("valid after reset");

endmodule

/* rtl/core/rvdec_slice.sv */
// ----------------------------------------------------------------------------
// rvdec_slice
// One pipeline register with valid/ready; takes a new beat while the held
// beat leaves in the same cycle.
// ----------------------------------------------------------------------------
module rvdec_slice #(
  parameter int unsigned WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic             valid;
  logic [WIDTH-1:0] data;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= in_data;
    end
  end

endmodule

/* rtl/core/rvdec_logic.sv */
// ----------------------------------------------------------------------------
// rvdec_logic
// Combinational decode of one RV32IM word into a micro-op.
// ----------------------------------------------------------------------------
module rvdec_logic import rvdec_pkg::*; (
  input  logic [INSTR_W-1:0] instr_word,
  output uop_t               uop
);

  logic [6:0]  opc;
  logic [4:0]  rd;
  logic [2:0]  f3;
  logic [4:0]  rs1;
  logic [4:0]  rs2;
  logic [6:0]  f7;
  logic [31:0] imm_i;
  logic [31:0] imm_s;
  logic [31:0] imm_b;
  logic [31:0] imm_u;
  logic [31:0] imm_j;
  logic [31:0] w;

  assign w     = instr_word;
  assign opc   = w[6:0];
  assign rd    = w[11:7];
  assign f3    = w[14:12];
  assign rs1   = w[19:15];
  assign rs2   = w[24:20];
  assign f7    = w[31:25];
  assign imm_i = {{20{w[31]}}, w[31:20]};
  assign imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
  assign imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
  assign imm_u = {w[31:12], 12'b0};
  assign imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};

  // fill the common fields of a decoded op
  function automatic uop_t mk(input unit_e_t u, input logic [4:0] op,
                              input logic [31:0] imm, input logic [4:0] d,
                              input logic [4:0] s1, input logic [4:0] s2,
                              input logic ui, input logic up);
    uop_t r;
    r.unit           = u;
    r.operation      = op;
    r.immediate      = imm;
    r.dest_reg       = d;
    r.src1_reg       = s1;
    r.src2_reg       = s2;
    r.uses_immediate = ui;
    r.uses_pc        = up;
    return r;
  endfunction

  always_comb begin
    uop = mk(UNIT_ILLEGAL, 5'd0, 32'd0, 5'd0, 5'd0, 5'd0, 1'b0, 1'b0);
    priority if (w == WORD_ECALL) begin
      uop.unit = UNIT_ECALL;
    end else if (w == WORD_EBREAK) begin
      uop.unit = UNIT_EBREAK;
    end else if (w == WORD_MRET) begin
      uop.unit = UNIT_MRET;
    end else if (w == WORD_SRET || w == WORD_WFI) begin
      uop.unit = UNIT_NOP;
    end else begin
      unique case (opc)
        OPC_AUIPC: uop = mk(UNIT_ALU, ALU_AUIPC, imm_u, rd, 5'd0, 5'd0, 1'b1, 1'b1);
        OPC_LUI:   uop = mk(UNIT_ALU, ALU_ADD, imm_u, rd, 5'd0, 5'd0, 1'b1, 1'b0);
        OPC_JAL:   uop = mk(UNIT_ALU, ALU_JAL, imm_j, rd, 5'd0, 5'd0, 1'b1, 1'b1);
        OPC_JALR:  uop = mk(UNIT_ALU, ALU_JALR, imm_i, rd, rs1, 5'd0, 1'b1, 1'b0);
        OPC_LOAD: begin
          // b, h, w, bu, hu
          if (f3 != 3'd3 && f3 < 3'd6) begin
            uop = mk(UNIT_LOAD, {2'b0, f3}, imm_i, rd, rs1, 5'd0, 1'b1, 1'b0);
          end
        end
        OPC_STORE: begin
          if (f3 <= F3_SW) begin
            uop = mk(UNIT_STORE, {2'b0, f3}, imm_s, 5'd0, rs1, rs2, 1'b1, 1'b0);
          end
        end
        OPC_BRANCH: begin
          if (f3 != 3'd2 && f3 != 3'd3) begin
            uop = mk(UNIT_BRANCH, {2'b0, f3}, imm_b, 5'd0, rs1, rs2, 1'b1, 1'b0);
          end
        end
        OPC_OP_IMM: begin
          // shifts carry the 5-bit amount; slli funct7 is not checked
          if (f3 == F3_SLL) begin
            uop = mk(UNIT_ALU, ALU_SLL, {27'd0, rs2}, rd, rs1, 5'd0, 1'b1, 1'b0);
          end else if (f3 == F3_SR) begin
            if (f7 == F7_BASE) begin
              uop = mk(UNIT_ALU, ALU_SRL, {27'd0, rs2}, rd, rs1, 5'd0, 1'b1, 1'b0);
            end else if (f7 == F7_ALT) begin
              uop = mk(UNIT_ALU, ALU_SRA, {27'd0, rs2}, rd, rs1, 5'd0, 1'b1, 1'b0);
            end
          end else begin
            uop = mk(UNIT_ALU, base_op(f3), imm_i, rd, rs1, 5'd0, 1'b1, 1'b0);
          end
        end
        OPC_OP: begin
          if (f7 == F7_BASE) begin
            uop = mk(UNIT_ALU, base_op(f3), 32'd0, rd, rs1, rs2, 1'b0, 1'b0);
          end else if (f7 == F7_MULDIV) begin
            uop = mk(UNIT_ALU, ALU_MUL + {2'b0, f3}, 32'd0, rd, rs1, rs2, 1'b0, 1'b0);
          end else if (f7 == F7_ALT && f3 == F3_ADD) begin
            uop = mk(UNIT_ALU, ALU_SUB, 32'd0, rd, rs1, rs2, 1'b0, 1'b0);
          end else if (f7 == F7_ALT && f3 == F3_SR) begin
            uop = mk(UNIT_ALU, ALU_SRA, 32'd0, rd, rs1, rs2, 1'b0, 1'b0);
          end
        end
        OPC_SYSTEM: begin
          if (f3 != F3_PRIV && f3 != F3_RSVD) begin
            uop = mk(UNIT_CSR, {2'b0, f3}, {20'd0, w[31:20]}, rd, rs1, 5'd0,
                     1'b1, 1'b0);
          end
        end
        OPC_MISC_MEM: uop.unit = UNIT_NOP;
        default: ;
      endcase
    end
  end

endmodule
